// ===== rtl/crp_pkg.sv =====
// shared types, codes and constants of the cell reference parser
// no dependencies; imported by every module of the block
`default_nettype none

package crp_pkg;

  // default accumulator widths
  localparam int unsigned ROW_BITS_DEF    = 21;
  localparam int unsigned COLUMN_BITS_DEF = 15;

  // fixed widths of the result fields and limit registers
  localparam int unsigned ROW_OUT_W  = 21;
  localparam int unsigned COL_OUT_W  = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned DIGIT_W    = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = 2'd1;

  // reset values of the limits
  localparam logic [ROW_OUT_W-1:0] ROW_LIMIT_RST    = 21'd1048576;
  localparam logic [COL_OUT_W-1:0] COLUMN_LIMIT_RST = 15'd16384;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;

  // radices of the column and row numbers
  localparam int unsigned COLUMN_RADIX = 26;
  localparam int unsigned ROW_RADIX    = 10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_MISSING  = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  // decoded form of one character
  typedef struct packed {
    logic                is_letter;
    logic                is_digit;
    logic [LETTER_W-1:0] letter_val;
    logic [DIGIT_W-1:0]  digit_val;
  } char_class_t;

  // one result transaction
  typedef struct packed {
    status_e              status;
    logic [ROW_OUT_W-1:0] row_number;
    logic [COL_OUT_W-1:0] column_number;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/crp_char_class.sv =====
// character decoder: letter or digit test and the value of each
// depends on crp_pkg
`default_nettype none

module crp_char_class
  import crp_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code_i,
  output char_class_t       class_o
);

  logic is_upper;
  logic is_lower;
  logic [CHAR_W-1:0] upper_off;
  logic [CHAR_W-1:0] lower_off;
  logic [CHAR_W-1:0] digit_off;

  // range tests
  assign is_upper = (char_code_i >= CHAR_UC_A) && (char_code_i <= CHAR_UC_Z);
  assign is_lower = (char_code_i >= CHAR_LC_A) && (char_code_i <= CHAR_LC_Z);

  // letter value 1..26 in either case, digit value 0..9
  assign upper_off = char_code_i - CHAR_UC_A + 8'd1;
  assign lower_off = char_code_i - CHAR_LC_A + 8'd1;
  assign digit_off = char_code_i - CHAR_0;

  assign class_o.is_letter  = is_upper || is_lower;
  assign class_o.is_digit   = (char_code_i >= CHAR_0) && (char_code_i <= CHAR_9);
  assign class_o.letter_val = is_upper ? upper_off[LETTER_W-1:0] : lower_off[LETTER_W-1:0];
  assign class_o.digit_val  = digit_off[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/crp_parse_core.sv =====
// parse state: column and row accumulators, flags and the status decision
// depends on crp_pkg; fed by crp_char_class
`default_nettype none

module crp_parse_core
  import crp_pkg::*;
#(
  parameter int unsigned ROW_BITS    = ROW_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 last_i,
  input  char_class_t          class_i,
  input  logic [ROW_OUT_W-1:0] row_limit_i,
  input  logic [COL_OUT_W-1:0] column_limit_i,
  output logic                 push_o,
  output result_t              result_o
);

  localparam int unsigned COL_EXT_W = COLUMN_BITS + 6;
  localparam int unsigned ROW_EXT_W = ROW_BITS + 4;
  localparam int unsigned ROW_CMP_W = (ROW_BITS > ROW_OUT_W) ? ROW_BITS : ROW_OUT_W;
  localparam int unsigned COL_CMP_W = (COLUMN_BITS > COL_OUT_W) ? COLUMN_BITS : COL_OUT_W;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;

  logic [COLUMN_BITS-1:0] column_accum_q, column_accum_d, column_accum_n;
  logic [ROW_BITS-1:0]    row_accum_q, row_accum_d, row_accum_n;
  logic column_overflow_q, column_overflow_d, column_overflow_n;
  logic row_overflow_q, row_overflow_d, row_overflow_n;
  logic seen_letter_q, seen_letter_d, seen_letter_n;
  logic seen_digit_q, seen_digit_d, seen_digit_n;
  logic bad_char_q, bad_char_d, bad_char_n;

  logic [COL_EXT_W-1:0] col_step;
  logic [ROW_EXT_W-1:0] row_step;
  logic                 out_of_range;

  // one multiply-add step for each accumulator
  assign col_step = COL_EXT_W'(column_accum_q) * COL_EXT_W'(COLUMN_RADIX)
                  + COL_EXT_W'(class_i.letter_val);
  assign row_step = ROW_EXT_W'(row_accum_q) * ROW_EXT_W'(ROW_RADIX)
                  + ROW_EXT_W'(class_i.digit_val);

  // state after the current character
  always_comb begin
    column_accum_n    = column_accum_q;
    column_overflow_n = column_overflow_q;
    row_accum_n       = row_accum_q;
    row_overflow_n    = row_overflow_q;
    seen_letter_n     = seen_letter_q;
    seen_digit_n      = seen_digit_q;
    bad_char_n        = bad_char_q;
    if (class_i.is_letter) begin
      if (seen_digit_q) begin
        bad_char_n = 1'b1;
      end else begin
        seen_letter_n = 1'b1;
        if (col_step > COL_EXT_W'(COL_MAX)) begin
          column_accum_n    = COL_MAX;
          column_overflow_n = 1'b1;
        end else begin
          column_accum_n = col_step[COLUMN_BITS-1:0];
        end
      end
    end else if (class_i.is_digit) begin
      seen_digit_n = 1'b1;
      if (row_step > ROW_EXT_W'(ROW_MAX)) begin
        row_accum_n    = ROW_MAX;
        row_overflow_n = 1'b1;
      end else begin
        row_accum_n = row_step[ROW_BITS-1:0];
      end
    end else begin
      bad_char_n = 1'b1;
    end
  end

  // range check against the limits
  assign out_of_range = row_overflow_n || column_overflow_n
                     || (row_accum_n == '0)
                     || (ROW_CMP_W'(row_accum_n) > ROW_CMP_W'(row_limit_i))
                     || (column_accum_n == '0)
                     || (COL_CMP_W'(column_accum_n) > COL_CMP_W'(column_limit_i));

  // status decision by priority: bad character, then missing part, then range
  always_comb begin
    result_o.row_number    = '0;
    result_o.column_number = '0;
    if (bad_char_n) begin
      result_o.status = ST_BAD_CHAR;
    end else if (!seen_letter_n || !seen_digit_n) begin
      result_o.status = ST_MISSING;
    end else if (out_of_range) begin
      result_o.status = ST_RANGE;
    end else begin
      result_o.status        = ST_OK;
      result_o.row_number    = ROW_OUT_W'(row_accum_n);
      result_o.column_number = COL_OUT_W'(column_accum_n);
    end
  end

  assign push_o = take_i && last_i;

  // next state: hold when idle, clear after the last character
  always_comb begin
    column_accum_d    = column_accum_q;
    column_overflow_d = column_overflow_q;
    row_accum_d       = row_accum_q;
    row_overflow_d    = row_overflow_q;
    seen_letter_d     = seen_letter_q;
    seen_digit_d      = seen_digit_q;
    bad_char_d        = bad_char_q;
    if (take_i) begin
      if (last_i) begin
        column_accum_d    = '0;
        column_overflow_d = 1'b0;
        row_accum_d       = '0;
        row_overflow_d    = 1'b0;
        seen_letter_d     = 1'b0;
        seen_digit_d      = 1'b0;
        bad_char_d        = 1'b0;
      end else begin
        column_accum_d    = column_accum_n;
        column_overflow_d = column_overflow_n;
        row_accum_d       = row_accum_n;
        row_overflow_d    = row_overflow_n;
        seen_letter_d     = seen_letter_n;
        seen_digit_d      = seen_digit_n;
        bad_char_d        = bad_char_n;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_accum_q    <= '0;
      column_overflow_q <= 1'b0;
      row_accum_q       <= '0;
      row_overflow_q    <= 1'b0;
      seen_letter_q     <= 1'b0;
      seen_digit_q      <= 1'b0;
      bad_char_q        <= 1'b0;
    end else begin
      column_accum_q    <= column_accum_d;
      column_overflow_q <= column_overflow_d;
      row_accum_q       <= row_accum_d;
      row_overflow_q    <= row_overflow_d;
      seen_letter_q     <= seen_letter_d;
      seen_digit_q      <= seen_digit_d;
      bad_char_q        <= bad_char_d;
    end
  end

`ifndef SYNTHESIS
  // an ok result carries a nonzero row and column
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (result_o.status == ST_OK) |->
      (result_o.row_number != '0) && (result_o.column_number != '0))
    else $error("ok result with zero row or column");

  // an error result carries zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (result_o.status != ST_OK) |->
      (result_o.row_number == '0) && (result_o.column_number == '0))
    else $error("error result with nonzero fields");

  // state is cleared after a reference ends
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !seen_letter_q && !seen_digit_q && !bad_char_q
               && (row_accum_q == '0) && (column_accum_q == '0))
    else $error("parse state not cleared after last character");
`endif

endmodule

`default_nettype wire

// ===== rtl/crp_out_buffer.sv =====
// two-entry result buffer: output register plus skid register
// depends on crp_pkg
`default_nettype none

module crp_out_buffer
  import crp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  // output register refills from the skid first, keeping order
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d       = skid_q;
        out_valid_d = 1'b1;
        if (push_i) begin
          skid_d = result_i;
        end else begin
          skid_valid_d = 1'b0;
        end
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = result_i;
        end
      end
    end else if (push_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  // the skid never holds a result ahead of an empty output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data while output register is empty");

  // no push lands on a full skid
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");

  // skid fills only while the receiver stalls
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && push_i))
    else $error("skid filled without a stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/cell_reference_parser_unit.sv =====
// top level of the cell reference parser: limit registers and wiring
// depends on crp_pkg, crp_char_class, crp_parse_core, crp_out_buffer
//
// Usage: the reference text enters one character per input transaction
// (char_code_i, last_char_i on in_valid_i/in_ready_o). Letters in either
// case form the column, digits the row; last_char_i marks the final byte.
// Only a transaction with last_char_i set makes a result transaction
// (status_o, row_number_o, column_number_o on out_valid_o/out_ready_i).
// Throughput: one character per cycle while in_ready_o is high. The result
// goes to the output register, or to the skid entry if the receiver stalls;
// the parse state itself is the only stage before the result register.
// A stalled receiver is absorbed by the output register plus one skid
// entry; in_ready_o drops only while both hold results.
// Limits are written on the cfg channel (index 0 row_limit, 1 column_limit,
// other indexes ignored); cfg_ready_o is always high and writes belong to
// idle periods. Reset clears the parse state and the buffer and loads the
// limits with 1048576 rows and 16384 columns.
`default_nettype none

module cell_reference_parser_unit
  import crp_pkg::*;
#(
  parameter int unsigned ROW_BITS    = ROW_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic                  last_char_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [ROW_OUT_W-1:0]  row_number_o,
  output logic [COL_OUT_W-1:0]  column_number_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [ROW_OUT_W-1:0] row_limit_q;
  logic [COL_OUT_W-1:0] column_limit_q;
  char_class_t          char_class;
  logic                 take;
  logic                 push;
  logic                 space;
  result_t              core_result;
  result_t              out_result;

  // limit registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q    <= ROW_LIMIT_RST;
      column_limit_q <= COLUMN_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW_LIMIT: begin
          row_limit_q <= cfg_data_i[ROW_OUT_W-1:0];
        end
        REG_COLUMN_LIMIT: begin
          column_limit_q <= cfg_data_i[COL_OUT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input transaction
  assign in_ready_o = space;
  assign take       = in_valid_i && space;

  crp_char_class u_char_class (
    .char_code_i (char_code_i),
    .class_o     (char_class)
  );

  crp_parse_core #(
    .ROW_BITS    (ROW_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_parse_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .last_i         (last_char_i),
    .class_i        (char_class),
    .row_limit_i    (row_limit_q),
    .column_limit_i (column_limit_q),
    .push_o         (push),
    .result_o       (core_result)
  );

  crp_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (core_result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  // result fields
  assign status_o        = out_result.status;
  assign row_number_o    = out_result.row_number;
  assign column_number_o = out_result.column_number;

endmodule

`default_nettype wire
